[rtl/fris_pkg.sv]
// Package for the FASTA record index scanner.
// Shared constants, opcodes and record flag type; no dependencies.
package fris_pkg;

  localparam int OFFSET_BITS_DEF = 40;
  localparam int COUNT_BITS_DEF  = 32;

  localparam logic [7:0] GT_CHAR = 8'h3E;
  localparam logic [7:0] NL_CHAR = 8'h0A;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOF  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic is_last;
    logic no_entries;
  } rec_flags_t;

endpackage

[rtl/fris_scan.sv]
// Scanner state and per-byte record logic.
// Depends on fris_pkg. Result fields are combinational from current state and the incoming item.
module fris_scan
  import fris_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [OFFSET_BITS-1:0] cfg_wdata,
  input  logic                   step,
  input  logic                   opcode,
  input  logic [7:0]             data_byte,
  output logic                   rec_valid,
  output logic [OFFSET_BITS-1:0] entry_offset,
  output logic [COUNT_BITS-1:0]  header_length,
  output logic [OFFSET_BITS-1:0] sequence_length,
  output logic [COUNT_BITS-1:0]  entry_index,
  output logic [OFFSET_BITS-1:0] max_entry_size,
  output rec_flags_t             flags
);

  localparam int WB = (OFFSET_BITS > COUNT_BITS) ? OFFSET_BITS : COUNT_BITS;
  localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  CMAX = {COUNT_BITS{1'b1}};

  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] byte_position;
  logic                   at_line_start;
  logic                   header_pending;
  logic [OFFSET_BITS-1:0] pending_start;
  logic                   have_entry;
  logic [OFFSET_BITS-1:0] entry_start;
  logic [COUNT_BITS-1:0]  entry_header_len;
  logic [COUNT_BITS-1:0]  entry_count;
  logic [OFFSET_BITS-1:0] max_span;

  logic                   is_eof;
  logic                   commit;
  logic [OFFSET_BITS-1:0] end_pos;
  logic [OFFSET_BITS-1:0] span;
  logic [WB-1:0]          span_w;
  logic [WB-1:0]          hl_w;
  logic [OFFSET_BITS-1:0] seq;
  logic [OFFSET_BITS-1:0] max_upd;
  logic [OFFSET_BITS-1:0] max_eof;
  logic [OFFSET_BITS-1:0] hl_raw;
  logic [WB-1:0]          hl_raw_w;
  logic [COUNT_BITS-1:0]  hl_sat;

  always_comb begin
    is_eof   = (opcode == OP_EOF);
    commit   = !is_eof && at_line_start && (data_byte != GT_CHAR) && header_pending;
    end_pos  = is_eof ? byte_position : pending_start;
    span     = end_pos - entry_start;
    span_w   = WB'(span);
    hl_w     = WB'(entry_header_len);
    seq      = (span_w > hl_w) ? OFFSET_BITS'(span_w - hl_w - WB'(1)) : '0;
    max_upd  = (span > max_span) ? span : max_span;
    max_eof  = have_entry ? max_upd : max_span;
    hl_raw   = byte_position - pending_start - OFFSET_BITS'(1);
    hl_raw_w = WB'(hl_raw);
    hl_sat   = (hl_raw_w > WB'(CMAX)) ? CMAX : COUNT_BITS'(hl_raw_w);

    rec_valid       = is_eof || (commit && have_entry);
    entry_offset    = have_entry ? entry_start : '0;
    header_length   = have_entry ? entry_header_len : '0;
    sequence_length = have_entry ? seq : '0;
    entry_index     = (have_entry && entry_count != '0) ? entry_count - COUNT_BITS'(1) : '0;
    max_entry_size  = '0;
    if (is_eof) begin
      max_entry_size = (max_eof == OMAX) ? OMAX : max_eof + OFFSET_BITS'(1);
    end
    flags.is_last    = is_eof;
    flags.no_entries = is_eof && !have_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset     <= '0;
      byte_position    <= '0;
      at_line_start    <= 1'b1;
      header_pending   <= 1'b0;
      pending_start    <= '0;
      have_entry       <= 1'b0;
      entry_start      <= '0;
      entry_header_len <= '0;
      entry_count      <= '0;
      max_span         <= '0;
    end else if (cfg_we) begin
      start_offset  <= cfg_wdata;
      byte_position <= cfg_wdata;
    end else if (step) begin
      if (is_eof) begin
        byte_position    <= start_offset;
        at_line_start    <= 1'b1;
        header_pending   <= 1'b0;
        pending_start    <= '0;
        have_entry       <= 1'b0;
        entry_start      <= '0;
        entry_header_len <= '0;
        entry_count      <= '0;
        max_span         <= '0;
      end else begin
        if (at_line_start && data_byte == GT_CHAR) begin
          pending_start  <= byte_position;
          header_pending <= 1'b1;
        end else if (commit) begin
          if (have_entry) begin
            max_span <= max_upd;
          end
          entry_start      <= pending_start;
          entry_header_len <= hl_sat;
          have_entry       <= 1'b1;
          if (entry_count != CMAX) begin
            entry_count <= entry_count + COUNT_BITS'(1);
          end
          header_pending <= 1'b0;
        end
        at_line_start <= (data_byte == NL_CHAR);
        byte_position <= byte_position + OFFSET_BITS'(1);
      end
    end
  end

endmodule

[rtl/fasta_record_index_scanner_top.sv]
// Top level of the FASTA record index scanner: stream ports and output skid stage.
// Depends on fris_pkg and fris_scan.
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tdata: data_byte; tuser: opcode
//  m_*       out   m_tvalid/m_tready  tdata: record fields; tlast: is_last; tuser: no_entries
//  cfg_*     in    cfg_we             cfg_wdata: start_offset
//
// One item per cycle while s_tready is high. Records land in the output register,
// or in a one-entry skid register when the output is stalled; s_tready drops
// only while the skid is full.
// Synchronous reset clears scanner state, start_offset and both output valid flags.
module fasta_record_index_scanner_top
  import fris_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [OFFSET_BITS-1:0] cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tuser,   // [0] opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // entry_offset, header_length, sequence_length, entry_index, max_entry_size
  output logic [((3*OFFSET_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_tdata,
  output logic                   m_tlast,   // is_last
  output logic                   m_tuser    // [0] no_entries
);

  localparam int FW = 3*OFFSET_BITS + 2*COUNT_BITS;
  localparam int DW = ((FW + 7) / 8) * 8;

  logic                   step;
  logic                   out_take;
  logic                   rec_valid;
  logic [OFFSET_BITS-1:0] entry_offset;
  logic [COUNT_BITS-1:0]  header_length;
  logic [OFFSET_BITS-1:0] sequence_length;
  logic [COUNT_BITS-1:0]  entry_index;
  logic [OFFSET_BITS-1:0] max_entry_size;
  rec_flags_t             flags;
  logic [DW-1:0]          rec_data;

  logic                   out_valid;
  logic [DW-1:0]          out_data;
  rec_flags_t             out_flags;
  logic                   skid_valid;
  logic [DW-1:0]          skid_data;
  rec_flags_t             skid_flags;

  fris_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .step           (step),
    .opcode         (s_tuser),
    .data_byte      (s_tdata),
    .rec_valid      (rec_valid),
    .entry_offset   (entry_offset),
    .header_length  (header_length),
    .sequence_length(sequence_length),
    .entry_index    (entry_index),
    .max_entry_size (max_entry_size),
    .flags          (flags)
  );

  assign s_tready = !skid_valid;
  assign step     = s_tvalid && s_tready;
  assign out_take = out_valid && m_tready;
  assign rec_data = DW'({max_entry_size, entry_index, sequence_length,
                         header_length, entry_offset});

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_flags.is_last;
  assign m_tuser  = out_flags.no_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_flags  <= skid_flags;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (step && rec_valid) begin
        out_data  <= rec_data;
        out_flags <= flags;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (step && rec_valid) begin
      skid_data  <= rec_data;
      skid_flags <= flags;
      skid_valid <= 1'b1;
    end
  end

endmodule

[tb/fris_record_checker.sv]
// Record checker for the FASTA record index scanner: watches the config port
// and both stream channels, predicts each index record and compares.
// Depends on fris_pkg.
module fris_record_checker
  import fris_pkg::*;
#(
  parameter int OB = OFFSET_BITS_DEF,
  parameter int CB = COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [OB-1:0]                        cfg_wdata,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [7:0]                           s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [((3*OB+2*CB+7)/8)*8-1:0]       m_tdata,
  input  logic                                 m_tlast,
  input  logic                                 m_tuser,
  output int                                   errors,
  output int                                   due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OB-1:0] OMAX = '1;
  localparam logic [CB-1:0] CMAX = '1;

  typedef struct packed {
    logic [OB-1:0] entry_offset;
    logic [CB-1:0] header_length;
    logic [OB-1:0] sequence_length;
    logic [CB-1:0] entry_index;
    logic [OB-1:0] max_entry_size;
    logic          is_last;
    logic          no_entries;
  } index_record_t;

  index_record_t records_due[$];
  int mismatches = 0;
  int due = 0;

  logic [OB-1:0] start_off = '0;
  logic [OB-1:0] scan_pos = '0;
  logic          at_line_start = 1'b1;
  logic          hdr_pending = 1'b0;
  logic [OB-1:0] pend_start = '0;
  logic          have_entry = 1'b0;
  logic [OB-1:0] entry_start = '0;
  logic [CB-1:0] entry_hlen = '0;
  logic [CB-1:0] entry_count = '0;
  logic [OB-1:0] max_span = '0;

  assign errors = mismatches;
  assign due_count = due;

  task automatic clear_scan();
    scan_pos = start_off;
    at_line_start = 1'b1;
    hdr_pending = 1'b0;
    pend_start = '0;
    have_entry = 1'b0;
    entry_start = '0;
    entry_hlen = '0;
    entry_count = '0;
    max_span = '0;
  endtask

  // record for the held entry, spanning up to end_pos
  task automatic close_entry(input logic [OB-1:0] end_pos, output index_record_t r);
    logic [OB-1:0] span;
    logic [OB-1:0] hlen_w;
    r = '0;
    hlen_w = entry_hlen;
    span = end_pos - entry_start;
    if (span > hlen_w) r.sequence_length = span - hlen_w - 1;
    if (span > max_span) max_span = span;
    r.entry_offset = entry_start;
    r.header_length = entry_hlen;
    r.entry_index = (entry_count == '0) ? '0 : entry_count - 1;
  endtask

  task automatic scan_item(input opcode_t op, input logic [7:0] b);
    index_record_t r;
    logic [OB-1:0] p;
    logic [OB-1:0] hl;
    r = '0;
    if (op == OP_EOF) begin
      if (have_entry) close_entry(scan_pos, r);
      r.max_entry_size = (max_span == OMAX) ? OMAX : max_span + 1;
      r.is_last = 1'b1;
      r.no_entries = !have_entry;
      records_due.push_back(r);
      clear_scan();
    end else begin
      p = scan_pos;
      if (at_line_start) begin
        if (b == GT_CHAR) begin
          pend_start = p;
          hdr_pending = 1'b1;
        end else if (hdr_pending) begin
          hl = p - pend_start - 1;
          if (have_entry) begin
            close_entry(pend_start, r);
            records_due.push_back(r);
          end
          entry_start = pend_start;
          entry_hlen = (hl > CMAX) ? CMAX : hl[CB-1:0];
          have_entry = 1'b1;
          if (entry_count != CMAX) entry_count = entry_count + 1;
          hdr_pending = 1'b0;
        end
      end
      at_line_start = (b == NL_CHAR);
      scan_pos = p + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    index_record_t want;
    index_record_t got;
    if (rst) begin
      start_off = '0;
      clear_scan();
      records_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.entry_offset    = m_tdata[OB-1:0];
        got.header_length   = m_tdata[OB+CB-1:OB];
        got.sequence_length = m_tdata[2*OB+CB-1:OB+CB];
        got.entry_index     = m_tdata[2*OB+2*CB-1:2*OB+CB];
        got.max_entry_size  = m_tdata[3*OB+2*CB-1:2*OB+2*CB];
        got.is_last         = m_tlast;
        got.no_entries      = m_tuser;
        if (records_due.size() == 0) begin
          mismatches++;
          $display("%0t: record with none expected, expected none, actual %h", $time,
                   got);
        end else begin
          want = records_due.pop_front();
          check_field("entry_offset", want.entry_offset, got.entry_offset);
          check_field("header_length", want.header_length, got.header_length);
          check_field("sequence_length", want.sequence_length, got.sequence_length);
          check_field("entry_index", want.entry_index, got.entry_index);
          check_field("max_entry_size", want.max_entry_size, got.max_entry_size);
          check_field("is_last", want.is_last, got.is_last);
          check_field("no_entries", want.no_entries, got.no_entries);
        end
      end
      if (cfg_we) begin
        start_off = cfg_wdata;
        scan_pos = cfg_wdata;
      end
      if (s_tvalid && s_tready) scan_item(opcode_t'(s_tuser), s_tdata);
    end
    due = records_due.size();
  end

endmodule

[tb/fasta_record_index_scanner_top_tb.sv]
// Testbench top for the FASTA record index scanner: drives FASTA byte streams
// with random gaps and stalls; fris_record_checker does prediction and compare.
// Depends on fris_pkg, fasta_record_index_scanner_top and fris_record_checker.
module fasta_record_index_scanner_top_tb
  import fris_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OB = OFFSET_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;
  localparam int DW = ((3*OB+2*CB+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 600;
  localparam logic [OB-1:0] OMAX = '1;

  logic          clk;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [OB-1:0] cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic          m_tlast;
  logic          m_tuser;

  int errors;
  int due_count;
  int src_idle = 27;
  int sink_idle = 47;
  int cycle_count = 0;

  logic [7:0] file_bytes[$];
  logic [7:0] bases[5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};

  fasta_record_index_scanner_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  fris_record_checker record_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .errors(errors), .due_count(due_count)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_idle);

  task automatic send_item(input opcode_t op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_item(OP_DATA, file_bytes[i]);
    send_item(OP_EOF, 8'($urandom_range(255)));
  endtask

  // wait for all records, plus the scanner's pipeline, before a config write
  task automatic drain();
    s_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_offset(input logic [OB-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [OB-1:0] pick_offset();
    logic [OB-1:0] v;
    case ($urandom_range(4))
      0: v = '0;
      1: v = OMAX;
      2: v = OMAX - OB'($urandom_range(40));
      3: v = {8'($urandom), 32'($urandom)};
      default: v = OB'($urandom_range(1000));
    endcase
    return v;
  endfunction

  task automatic make_file();
    int kind;
    logic [7:0] b;
    file_bytes.delete();
    kind = $urandom_range(9);
    if (kind == 0) begin
      // noise with frequent markers and newlines
      repeat ($urandom_range(1, 40)) begin
        case ($urandom_range(3))
          0: b = GT_CHAR;
          1: b = NL_CHAR;
          default: b = 8'($urandom_range(255));
        endcase
        file_bytes.push_back(b);
      end
    end else begin
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(5) == 0) file_bytes.push_back(NL_CHAR);
        file_bytes.push_back(GT_CHAR);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(255));
          if (b == NL_CHAR) b = 8'h20;
          file_bytes.push_back(b);
        end
        file_bytes.push_back(NL_CHAR);
        repeat ($urandom_range(0, 3)) begin
          repeat ($urandom_range(0, 12)) file_bytes.push_back(bases[$urandom_range(4)]);
          file_bytes.push_back(NL_CHAR);
        end
      end
      if (kind == 1) begin
        // header left open at end of file
        file_bytes.push_back(GT_CHAR);
        repeat ($urandom_range(0, 4)) file_bytes.push_back(8'h61);
        if ($urandom_range(1) == 1) file_bytes.push_back(NL_CHAR);
      end else if (kind == 2 && file_bytes.size() > 0) begin
        void'(file_bytes.pop_back());
      end
    end
  endtask

  initial begin
    int ph;
    int sent;
    logic first;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty stream
    file_bytes.delete();
    send_file();
    // header replaced by a later header line, positions wrapping past the top
    drain();
    write_offset(OMAX);
    file_bytes = '{GT_CHAR, 8'h41, NL_CHAR, 8'h43, NL_CHAR, GT_CHAR, 8'h00, NL_CHAR,
                   GT_CHAR, 8'hFF, NL_CHAR, 8'h47};
    send_file();
    // header whose newline is the last byte
    file_bytes = '{GT_CHAR, 8'h78, NL_CHAR};
    send_file();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle = 27; sink_idle = 47; end
        1: begin src_idle = 47; sink_idle = 27; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      sent = 0;
      first = 1'b1;
      while (sent < PHASE_ITEMS) begin
        if (first || $urandom_range(3) == 0) begin
          drain();
          write_offset(pick_offset());
        end
        first = 1'b0;
        make_file();
        send_file();
        sent += file_bytes.size() + 1;
      end
    end

    s_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && due_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
